/* hw/rtl/sobel_edge_filter_assert.svh */
// Assertion macros for the edge filter
`ifndef SOBEL_EDGE_FILTER_ASSERT_SVH
`define SOBEL_EDGE_FILTER_ASSERT_SVH
`define SEF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hw/rtl/sef_pkg.sv */
// Shared types, constants and arithmetic helpers of the edge filter
`default_nettype none
package sef_pkg;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIX_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd2;
    localparam logic [10:0] LINE_WIDTH_RST = 11'd640;
    localparam logic [35:0] KERNEL_RST = 36'hFEF000121;

    // control from pixel front end to the filter datapath
    typedef struct packed {
        logic emit;
        logic row_end;
    } t_win_ctl;

    // clamp a signed kernel sum into a byte
    function automatic logic [7:0] clamp_byte(input logic signed [15:0] v);
        logic [7:0] r;
        if (v < 0) begin
            r = 8'd0;
        end else if (v > 16'sd255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/sef_ram.sv */
// Generic single-port-write, registered-read RAM
`default_nettype none
module sef_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/sef_isqrt.sv */
// Iterative integer square root, one result bit per cycle
`default_nettype none
module sef_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [16:0] i_x,
    output logic             o_done,
    output logic [7:0]       o_root
);
    logic [16:0] r_rem, n_rem;
    logic [16:0] r_res, n_res;
    logic [3:0]  r_step, n_step;
    logic        r_busy, n_busy;
    logic [18:0] trial;
    logic [16:0] bitv;

    // bit = 4^step; the partial result runs as wide as the operand, the root is capped to 8
    assign bitv = 17'd1 << {r_step, 1'b0};
    assign trial = {2'b00, r_rem} - ({2'b00, r_res} + {2'b00, bitv});

    always_comb begin
        n_rem = r_rem;
        n_res = r_res;
        n_step = r_step;
        n_busy = r_busy;
        o_done = 1'b0;
        if (i_start) begin
            n_rem = i_x;
            n_res = 17'd0;
            n_step = 4'd8;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[18]) begin
                n_rem = trial[16:0];
                n_res = (r_res >> 1) + bitv;
            end else begin
                n_res = r_res >> 1;
            end
            if (r_step == 4'd0) begin
                n_busy = 1'b0;
                o_done = 1'b1;
            end else begin
                n_step = r_step - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_rem <= n_rem;
        r_res <= n_res;
        r_step <= n_step;
    end

    assign o_root = (n_res > 17'd255) ? 8'd255 : n_res[7:0];
endmodule
`default_nettype wire

/* hw/rtl/sef_kernel.sv */
// Per-channel 3x3 kernel sums, clamping and gradient magnitude
`default_nettype none
module sef_kernel (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [sef_pkg::PIX_W-1:0]  i_win [9],
    input  wire logic                       i_mode,
    input  wire logic [35:0]                i_coeffs,
    output logic                            o_done,
    output logic [sef_pkg::PIX_W-1:0]       o_pix
);
    logic [7:0]  r_a [3];
    logic [7:0]  r_b [3];
    logic [7:0]  r_out [3];
    logic [1:0]  r_ch, n_ch;
    logic [1:0]  r_st, n_st;
    logic        r_done, n_done;
    logic [7:0]  a_c [3];
    logic [7:0]  b_c [3];
    logic [7:0]  p_c [3];
    logic        sq_start, sq_done;
    logic [16:0] sq_x;
    logic [7:0]  sq_root;
    logic [7:0]  cur_a, cur_b;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQRT = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    always_comb begin
        logic signed [15:0] sp, sa, sb, px;
        logic signed [4:0]  k;
        for (int ch = 0; ch < 3; ch++) begin
            sp = '0;
            for (int i = 0; i < 9; i++) begin
                px = 16'(signed'({1'b0, i_win[i][8*ch +: 8]}));
                k = 5'(signed'(i_coeffs[4*i +: 4]));
                sp = sp + px * 16'(k);
            end
            sa = 16'(signed'({1'b0, i_win[0][8*ch +: 8]}))
               + 16'(signed'({1'b0, i_win[1][8*ch +: 8], 1'b0}))
               + 16'(signed'({1'b0, i_win[2][8*ch +: 8]}))
               - 16'(signed'({1'b0, i_win[6][8*ch +: 8]}))
               - 16'(signed'({1'b0, i_win[7][8*ch +: 8], 1'b0}))
               - 16'(signed'({1'b0, i_win[8][8*ch +: 8]}));
            sb = 16'(signed'({1'b0, i_win[2][8*ch +: 8]}))
               + 16'(signed'({1'b0, i_win[5][8*ch +: 8], 1'b0}))
               + 16'(signed'({1'b0, i_win[8][8*ch +: 8]}))
               - 16'(signed'({1'b0, i_win[0][8*ch +: 8]}))
               - 16'(signed'({1'b0, i_win[3][8*ch +: 8], 1'b0}))
               - 16'(signed'({1'b0, i_win[6][8*ch +: 8]}));
            p_c[ch] = sef_pkg::clamp_byte(sp);
            a_c[ch] = sef_pkg::clamp_byte(sa);
            b_c[ch] = sef_pkg::clamp_byte(sb);
        end
    end

    assign cur_a = r_a[r_ch];
    assign cur_b = r_b[r_ch];
    assign sq_x = ({9'd0, cur_a} * {9'd0, cur_a}) + ({9'd0, cur_b} * {9'd0, cur_b});
    assign sq_start = (r_st == ST_SQRT);

    sef_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sq_start),
        .i_x    (sq_x),
        .o_done (sq_done),
        .o_root (sq_root)
    );

    // done stays high until the next start, once every channel is in r_out
    always_comb begin
        n_st = r_st;
        n_ch = r_ch;
        n_done = r_done;
        case (r_st)
            ST_IDLE: begin
                if (i_start) begin
                    n_done = !i_mode;
                    if (i_mode) begin
                        n_st = ST_SQRT;
                        n_ch = 2'd0;
                    end
                end
            end
            ST_SQRT: n_st = ST_WAIT;
            ST_WAIT: begin
                if (sq_done) begin
                    if (r_ch == 2'd2) begin
                        n_st = ST_IDLE;
                        n_done = 1'b1;
                    end else begin
                        n_ch = r_ch + 2'd1;
                        n_st = ST_SQRT;
                    end
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ch <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ch <= n_ch;
            r_done <= n_done;
        end
        if (i_start) begin
            for (int c = 0; c < 3; c++) begin
                r_a[c] <= a_c[c];
                r_b[c] <= b_c[c];
                r_out[c] <= p_c[c];
            end
        end else if (sq_done) begin
            r_out[r_ch] <= sq_root;
        end
    end

    assign o_done = r_done;
    assign o_pix = {r_out[2], r_out[1], r_out[0]};
endmodule
`default_nettype wire

/* hw/rtl/sobel_edge_filter.sv */
// Edge filter top level: line stores, window and result register
// An accepted pixel passes the read and calc states, and the out state when it makes a
// result; mode 1 adds three iterative roots, one per channel. No new pixel is accepted
// until the previous one is back in idle.
// A stalled result holds the input off until the output register frees up.
// Reset (i_rst_n low, synchronous) clears counters, window and registers to defaults.
`default_nettype none
module sobel_edge_filter #(
    parameter int MAX_WIDTH = sef_pkg::MAX_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_red,
    input  wire logic [7:0]  i_in_green,
    input  wire logic [7:0]  i_in_blue,
    input  wire logic        i_frame_start,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    output logic             o_row_end,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [sef_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [35:0] i_cfg_data
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [10:0] r_line_width;
    logic        r_edge_mode;
    logic [35:0] r_kernel;
    logic [1:0]  r_state, n_state;
    logic [CW-1:0] r_col;
    logic [1:0]  r_rows;
    logic [CW-1:0] eff_w, col_a;
    logic [1:0]  rows_a;
    logic [CW-1:0] r_cur_col;
    logic [sef_pkg::PIX_W-1:0] r_pix;
    logic [sef_pkg::PIX_W-1:0] up_q, mid_q;
    logic [sef_pkg::PIX_W-1:0] r_win [9];
    sef_pkg::t_win_ctl r_ctl;
    logic        kstart, kdone;
    logic [sef_pkg::PIX_W-1:0] kpix;
    logic        acc_in, acc_out;
    logic        out_load;
    logic [AW-1:0] ram_addr;
    logic        ram_we;
    logic [sef_pkg::PIX_W-1:0] r_opix;
    logic        r_orow;
    logic        r_ovalid;
    logic [CW-1:0] col_n;

    assign acc_in = i_valid && !o_stall;
    assign acc_out = r_ovalid && !i_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_line_width < 11'd3) begin
            eff_w = CW'(3);
        end else if (32'(r_line_width) > MAX_WIDTH) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(r_line_width);
        end
        col_a = r_col;
        rows_a = r_rows;
        if (i_frame_start) begin
            col_a = '0;
            rows_a = 2'd0;
        end
        if (col_a >= eff_w) begin
            col_a = '0;
            if (rows_a < 2'd2) begin
                rows_a = rows_a + 2'd1;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign ram_addr = (r_state == S_IDLE) ? col_a[AW-1:0] : r_cur_col[AW-1:0];
    assign ram_we = (r_state == S_READ);
    assign col_n = r_cur_col + CW'(1);

    sef_ram #(.WIDTH(sef_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_addr), .i_wdata(mid_q),
        .i_raddr(ram_addr), .o_rdata(up_q)
    );
    sef_ram #(.WIDTH(sef_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_addr), .i_wdata(r_pix),
        .i_raddr(ram_addr), .o_rdata(mid_q)
    );

    assign kstart = (r_state == S_CALC) && r_ctl.emit;

    sef_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (kstart),
        .i_win   (r_win),
        .i_mode  (r_edge_mode),
        .i_coeffs(r_kernel),
        .o_done  (kdone),
        .o_pix   (kpix)
    );

    // move the result out once the kernel is done and the output register is free
    assign out_load = (r_state == S_OUT) && kdone && (!r_ovalid || acc_out);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (acc_in) n_state = S_READ;
            S_READ: n_state = S_CALC;
            S_CALC: begin
                if (!r_ctl.emit) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= sef_pkg::LINE_WIDTH_RST;
            r_edge_mode <= 1'b0;
            r_kernel <= sef_pkg::KERNEL_RST;
            r_state <= S_IDLE;
            r_col <= '0;
            r_rows <= 2'd0;
            r_ovalid <= 1'b0;
            r_ctl <= '0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sef_pkg::REG_LINE_WIDTH: r_line_width <= i_cfg_data[10:0];
                    sef_pkg::REG_EDGE_MODE:  r_edge_mode <= i_cfg_data[0];
                    sef_pkg::REG_KERNEL:     r_kernel <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
                r_opix <= kpix;
                r_orow <= r_ctl.row_end;
            end else if (acc_out) begin
                r_ovalid <= 1'b0;
            end
            if (acc_in) begin
                r_cur_col <= col_a;
                r_pix <= {i_in_blue, i_in_green, i_in_red};
                r_ctl.emit <= (rows_a == 2'd2) && (col_a >= CW'(2));
                r_ctl.row_end <= (col_a + CW'(1)) >= eff_w;
                r_rows <= rows_a;
            end
            if (r_state == S_READ) begin
                // shift the window, take the new column from the line stores and the current pixel
                for (int i = 0; i < 3; i++) begin
                    r_win[i*3]   <= r_win[i*3+1];
                    r_win[i*3+1] <= r_win[i*3+2];
                end
                r_win[2] <= up_q;
                r_win[5] <= mid_q;
                r_win[8] <= r_pix;
                if (col_n >= eff_w) begin
                    r_col <= '0;
                    if (r_rows < 2'd2) begin
                        r_rows <= r_rows + 2'd1;
                    end
                end else begin
                    r_col <= col_n;
                end
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_out_red = r_opix[7:0];
    assign o_out_green = r_opix[15:8];
    assign o_out_blue = r_opix[23:16];
    assign o_row_end = r_orow;

`include "sobel_edge_filter_assert.svh"
    `SEF_ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall,
        "pixel request accepted while busy")
    `SEF_ASSERT_NEXT(a_read_then_calc, i_clk, i_rst_n, r_state == S_READ,
        r_state == S_CALC, "read phase not followed by kernel phase")
    `SEF_ASSERT_IMPL(a_row_bounds, i_clk, i_rst_n, 1'b1, r_rows <= 2'd2,
        "row counter beyond saturation")
endmodule
`default_nettype wire
